/* sv/stsd_pkg.sv */
// Shared types and constants for the sorted tuple set difference block.
package stsd_pkg;

  localparam int FIELD_W = 64;
  localparam int KIND_W  = 2;
  localparam int ARITY_W = 2;

  localparam logic [ARITY_W-1:0] ARITY_ONE   = 2'd1;
  localparam logic [ARITY_W-1:0] ARITY_RESET = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_PROBE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t op;
  } cmd_ctl_t;

endpackage

/* sv/sorted_tuple_set_difference.sv */
// Top level of the sorted tuple set difference block.
// Clears and appends leave the command queue at one per cycle while no probe is in progress. A
// probe is first taken from the queue, then compares stored tuples in turn, including the one
// that matches it or is larger than it; a kept probe then loads the result register, and waits
// there while that register still holds an earlier result that has not been taken. A probe that
// finds the store already exhausted goes straight to loading the result register. The walk reads
// one stored tuple per cycle through the single read port of the tuple store, and each stored
// tuple is passed only once between clears. The input side keeps accepting into a two-entry
// queue while the merge walk runs, and a finished result waits in its own register so the next
// probe can proceed. Terms are reduced to TERM_BITS bits, and kept_second reads zero while arity
// is one. No clearing pass runs after reset.
module sorted_tuple_set_difference #(
  parameter int STORE_DEPTH = 1024,
  parameter int TERM_BITS   = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [stsd_pkg::ARITY_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stsd_pkg::KIND_W-1:0]  kind,
  input  logic [stsd_pkg::FIELD_W-1:0] first_value,
  input  logic [stsd_pkg::FIELD_W-1:0] second_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stsd_pkg::FIELD_W-1:0] kept_first,
  output logic [stsd_pkg::FIELD_W-1:0] kept_second
);
  import stsd_pkg::*;

  logic [ARITY_W-1:0]   arity;
  cmd_ctl_t             q_ctl;
  logic                 q_ready;
  logic [TERM_BITS-1:0] q_a;
  logic [TERM_BITS-1:0] q_b;

  stsd_front #(
    .TERM_BITS (TERM_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .arity        (arity),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .first_value  (first_value),
    .second_value (second_value),
    .q_ctl        (q_ctl),
    .q_ready      (q_ready),
    .q_a          (q_a),
    .q_b          (q_b)
  );

  stsd_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .TERM_BITS   (TERM_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .arity       (arity),
    .q_ctl       (q_ctl),
    .q_ready     (q_ready),
    .q_a         (q_a),
    .q_b         (q_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kept_first  (kept_first),
    .kept_second (kept_second)
  );

endmodule

/* sv/stsd_front.sv */
// Front end: arity register, input classification and a two-entry command queue.
module stsd_front #(
  parameter int TERM_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [stsd_pkg::ARITY_W-1:0] cfg_data,
  output logic [stsd_pkg::ARITY_W-1:0] arity,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stsd_pkg::KIND_W-1:0]  kind,
  input  logic [stsd_pkg::FIELD_W-1:0] first_value,
  input  logic [stsd_pkg::FIELD_W-1:0] second_value,
  output stsd_pkg::cmd_ctl_t           q_ctl,
  input  logic                         q_ready,
  output logic [TERM_BITS-1:0]         q_a,
  output logic [TERM_BITS-1:0]         q_b
);
  import stsd_pkg::*;

  kind_t                op_arr [2];
  logic [TERM_BITS-1:0] a_arr  [2];
  logic [TERM_BITS-1:0] b_arr  [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           fill;
  logic                 known_kind;
  logic                 push;
  logic                 pop;
  logic [TERM_BITS-1:0] in_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      arity <= ARITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      arity <= cfg_data;
    end
  end

  // Unknown kinds are taken and dropped here.
  assign known_kind = (kind == KIND_CLEAR) || (kind == KIND_APPEND) || (kind == KIND_PROBE);
  assign in_ready   = (fill != 2'd2);
  assign push       = in_valid && in_ready && known_kind;
  assign pop        = q_ctl.valid && q_ready;
  assign in_b       = ((arity == ARITY_ONE) && (kind == KIND_PROBE)) ? '0 :
                      second_value[TERM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      op_arr[wr_ptr] <= kind_t'(kind);
      a_arr[wr_ptr]  <= first_value[TERM_BITS-1:0];
      b_arr[wr_ptr]  <= in_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  assign q_ctl.valid = (fill != 2'd0);
  assign q_ctl.op    = op_arr[rd_ptr];
  assign q_a         = a_arr[rd_ptr];
  assign q_b         = b_arr[rd_ptr];

endmodule

/* sv/stsd_back.sv */
// Back end: tuple store, merge pointer walk and the result register.
module stsd_back #(
  parameter int STORE_DEPTH = 1024,
  parameter int TERM_BITS   = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [stsd_pkg::ARITY_W-1:0] arity,
  input  stsd_pkg::cmd_ctl_t           q_ctl,
  output logic                         q_ready,
  input  logic [TERM_BITS-1:0]         q_a,
  input  logic [TERM_BITS-1:0]         q_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stsd_pkg::FIELD_W-1:0] kept_first,
  output logic [stsd_pkg::FIELD_W-1:0] kept_second
);
  import stsd_pkg::*;

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  logic [2*TERM_BITS-1:0] mem [STORE_DEPTH];
  logic [2*TERM_BITS-1:0] rd_data;
  logic [IW-1:0]          rd_addr;
  logic                   wr_en;

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        ptr, ptr_next;
  logic [CW-1:0]        ptr_inc;
  logic [TERM_BITS-1:0] pa, pb;
  logic [TERM_BITS-1:0] kept_a, kept_b;
  logic [TERM_BITS-1:0] sa, sb;
  logic                 lt, eq;
  logic                 out_free;
  logic                 load_out;
  logic                 take_probe;

  assign sa = rd_data[2*TERM_BITS-1:TERM_BITS];
  assign sb = rd_data[TERM_BITS-1:0];

  always_comb begin
    if (arity == ARITY_ONE) begin
      lt = (sa < pa);
      eq = (sa == pa);
    end else begin
      lt = (sa < pa) || ((sa == pa) && (sb < pb));
      eq = (sa == pa) && (sb == pb);
    end
  end

  assign q_ready  = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign ptr_inc  = ptr + CW'(1);

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    rd_addr    = ptr[IW-1:0];
    wr_en      = 1'b0;
    load_out   = 1'b0;
    take_probe = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_ctl.valid) begin
          case (q_ctl.op)
            KIND_CLEAR: begin
              count_next = '0;
              ptr_next   = '0;
            end
            KIND_APPEND: begin
              if (count < CW'(STORE_DEPTH)) begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
            end
            KIND_PROBE: begin
              take_probe = 1'b1;
              state_next = (ptr < count) ? S_CMP : S_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        if (eq) begin
          ptr_next   = ptr_inc;
          state_next = S_IDLE;
        end else if (lt) begin
          ptr_next = ptr_inc;
          rd_addr  = ptr_inc[IW-1:0];
          if (!(ptr_inc < count)) begin
            state_next = S_EMIT;
          end
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IW-1:0]] <= {q_a, q_b};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ptr   <= ptr_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_probe) begin
      pa <= q_a;
      pb <= q_b;
    end
    if (load_out) begin
      kept_a <= pa;
      kept_b <= pb;
    end
  end

  assign kept_first  = FIELD_W'(kept_a);
  assign kept_second = FIELD_W'(kept_b);

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst) ptr <= count)
    else $error("merge pointer passed the fill count");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STORE_DEPTH))
    else $error("fill count exceeds store depth");
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (ptr < count))
    else $error("compare state entered with the store exhausted");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && q_ctl.valid && q_ctl.op == KIND_CLEAR) |=> (count == '0 && ptr == '0))
    else $error("clear did not reset the store and pointer");

endmodule
